@@ rtl/core/ddlm_pkg.sv @@
// shared types, codes and rectangle helpers for the damage list merger
// no dependencies; used by ddlm_ctrl, ddlm_dp and the top level
package ddlm_pkg;

  // input modes
  localparam logic [2:0] MODE_RECT    = 3'd0;
  localparam logic [2:0] MODE_SCROLL  = 3'd1;
  localparam logic [2:0] MODE_COMPACT = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  // rectangle kinds
  localparam logic [1:0] KIND_NORMAL  = 2'd0;
  localparam logic [1:0] KIND_REPAIR  = 2'd1;
  localparam logic [1:0] KIND_EXPOSED = 2'd2;

  // entry type codes
  localparam logic [2:0] T_NONE    = 3'd0;
  localparam logic [2:0] T_RECT    = 3'd1;
  localparam logic [2:0] T_REPAIR  = 3'd2;
  localparam logic [2:0] T_EXPOSED = 3'd3;
  localparam logic [2:0] T_SCROLL  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_IGNORED       = 3'd0;
  localparam logic [2:0] ST_QUEUED        = 3'd1;
  localparam logic [2:0] ST_MERGED        = 3'd2;
  localparam logic [2:0] ST_FALLBACK      = 3'd3;
  localparam logic [2:0] ST_COMPACTED     = 3'd4;
  localparam logic [2:0] ST_NOT_COMPACTED = 3'd5;
  localparam logic [2:0] ST_DONE          = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_BOUND_X = 2'd0;
  localparam logic [1:0] CFG_BOUND_Y = 2'd1;
  localparam logic [1:0] CFG_BOUND_W = 2'd2;
  localparam logic [1:0] CFG_BOUND_H = 2'd3;

  // decoded operation classes
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_RECT    = 3'd1;
  localparam logic [2:0] OP_SCROLL  = 3'd2;
  localparam logic [2:0] OP_COMPACT = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  // read address sources
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_CNT  = 2'd2;
  localparam logic [1:0] RD_IDX  = 2'd3;

  // list write operations
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_PUSH  = 3'd1;
  localparam logic [2:0] WR_OVF   = 3'd2;
  localparam logic [2:0] WR_HIT   = 3'd3;
  localparam logic [2:0] WR_REPL  = 3'd4;
  localparam logic [2:0] WR_CLEAR = 3'd5;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  typedef struct packed {
    logic [15:0] rows;
    logic [2:0]  etype;
    box_t        geo;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  area_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [15:0] scroll_distance;
    logic [7:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  damage_cnt;
    logic [8:0]  scroll_cnt;
    logic [39:0] total_pixels;
    logic [31:0] largest_area;
    logic        fallback_active;
    logic [2:0]  entry_type;
    logic [15:0] entry_x;
    logic [15:0] entry_y;
    logic [15:0] entry_width;
    logic [15:0] entry_height;
    logic [15:0] entry_distance;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       cnt_total;
    logic       cnt_clear;
    logic       cnt_dec;
    logic       cnt_inc;
    logic [1:0] rd_sel;
    logic [2:0] wr_op;
    logic       set_status;
    logic [2:0] status;
    logic       acc_init;
    logic       cmp_acc;
    logic       st_init;
    logic       st_mul;
    logic       st_acc;
    logic       cap_entry;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fallback;
    logic       cnt_zero;
    logic       cnt_at_total;
    logic       full;
    logic       idx_ok;
    logic       hit;
    logic       cont;
    logic       sc_gt1;
  } sts_t;

  function automatic logic box_empty(box_t b);
    return (b.w == 16'd0) || (b.h == 16'd0);
  endfunction

  function automatic box_t box_clip(box_t a, box_t b);
    logic [15:0] l;
    logic [15:0] t;
    logic [16:0] ra;
    logic [16:0] rb;
    logic [16:0] ba;
    logic [16:0] bb;
    logic [16:0] rr;
    logic [16:0] bo;
    box_t        r;
    l  = (a.x > b.x) ? a.x : b.x;
    t  = (a.y > b.y) ? a.y : b.y;
    ra = {1'b0, a.x} + {1'b0, a.w};
    rb = {1'b0, b.x} + {1'b0, b.w};
    ba = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    rr = (ra < rb) ? ra : rb;
    bo = (ba < bb) ? ba : bb;
    r  = '0;
    if (!((rr <= {1'b0, l}) || (bo <= {1'b0, t}))) begin
      r.x = l;
      r.y = t;
      r.w = 16'(rr - {1'b0, l});
      r.h = 16'(bo - {1'b0, t});
    end
    return r;
  endfunction

  function automatic box_t box_bound(box_t a, box_t b);
    logic [16:0] ra;
    logic [16:0] rb;
    logic [16:0] ba;
    logic [16:0] bb;
    logic [16:0] dw;
    logic [16:0] dh;
    box_t        r;
    ra  = {1'b0, a.x} + {1'b0, a.w};
    rb  = {1'b0, b.x} + {1'b0, b.w};
    ba  = {1'b0, a.y} + {1'b0, a.h};
    bb  = {1'b0, b.y} + {1'b0, b.h};
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    dw  = ((ra > rb) ? ra : rb) - {1'b0, r.x};
    dh  = ((ba > bb) ? ba : bb) - {1'b0, r.y};
    r.w = dw[16] ? 16'hFFFF : dw[15:0];
    r.h = dh[16] ? 16'hFFFF : dh[15:0];
    if (box_empty(a)) begin
      r = b;
    end else if (box_empty(b)) begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic box_touch(box_t a, box_t b);
    logic [16:0] ab;
    logic [16:0] bb;
    logic [16:0] ar;
    logic [16:0] br;
    logic        res;
    ab  = {1'b0, a.y} + {1'b0, a.h};
    bb  = {1'b0, b.y} + {1'b0, b.h};
    ar  = {1'b0, a.x} + {1'b0, a.w};
    br  = {1'b0, b.x} + {1'b0, b.w};
    res = !box_empty(box_clip(a, b));
    if ((a.x == b.x) && (a.w == b.w) && ((ab == {1'b0, b.y}) || (bb == {1'b0, a.y}))) begin
      res = 1'b1;
    end
    if ((a.y == b.y) && (a.h == b.h) && ((ar == {1'b0, b.x}) || (br == {1'b0, a.x}))) begin
      res = 1'b1;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/ddlm_ctrl.sv @@
// sequencer for the damage list merger: decode, list scan, compaction, statistics
// depends on ddlm_pkg; drives ddlm_dp through cmd_t and reads sts_t
module ddlm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ddlm_pkg::sts_t sts_i,
  output ddlm_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_CMP_RD   = 4'd4;
  localparam logic [3:0] S_CMP_CHK  = 4'd5;
  localparam logic [3:0] S_CMP_END  = 4'd6;
  localparam logic [3:0] S_RD_CAP   = 4'd7;
  localparam logic [3:0] S_ST_INIT  = 4'd8;
  localparam logic [3:0] S_ST_RD    = 4'd9;
  localparam logic [3:0] S_ST_MUL   = 4'd10;
  localparam logic [3:0] S_ST_ACC   = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_ST_INIT;
        case (sts_i.op)
          ddlm_pkg::OP_RECT, ddlm_pkg::OP_SCROLL: begin
            if (sts_i.fallback) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ddlm_pkg::ST_FALLBACK;
            end else begin
              cmd_o.cnt_total = 1'b1;
              state_d         = S_SCAN_RD;
            end
          end
          ddlm_pkg::OP_COMPACT: begin
            if (sts_i.fallback) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ddlm_pkg::ST_NOT_COMPACTED;
            end else begin
              cmd_o.cnt_clear = 1'b1;
              cmd_o.acc_init  = 1'b1;
              state_d         = S_CMP_RD;
            end
          end
          ddlm_pkg::OP_CLEAR: begin
            cmd_o.wr_op      = ddlm_pkg::WR_CLEAR;
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ddlm_pkg::ST_DONE;
          end
          ddlm_pkg::OP_READ: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ddlm_pkg::ST_DONE;
            if (sts_i.idx_ok) begin
              cmd_o.rd_sel = ddlm_pkg::RD_IDX;
              state_d      = S_RD_CAP;
            end
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ddlm_pkg::ST_IGNORED;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts_i.cnt_zero) begin
          cmd_o.set_status = 1'b1;
          if (sts_i.full) begin
            cmd_o.wr_op  = ddlm_pkg::WR_OVF;
            cmd_o.status = ddlm_pkg::ST_FALLBACK;
          end else begin
            cmd_o.wr_op  = ddlm_pkg::WR_PUSH;
            cmd_o.status = ddlm_pkg::ST_QUEUED;
          end
          state_d = S_ST_INIT;
        end else begin
          cmd_o.rd_sel = ddlm_pkg::RD_PREV;
          state_d      = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        state_d = S_SCAN_RD;
        if (sts_i.hit) begin
          cmd_o.wr_op      = ddlm_pkg::WR_HIT;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ddlm_pkg::ST_MERGED;
          state_d          = S_ST_INIT;
        end else if (sts_i.cont) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.cnt_clear = 1'b1;
        end
      end
      S_CMP_RD: begin
        if (sts_i.cnt_at_total) begin
          state_d = S_CMP_END;
        end else begin
          cmd_o.rd_sel = ddlm_pkg::RD_CNT;
          state_d      = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        cmd_o.cmp_acc = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_CMP_RD;
      end
      S_CMP_END: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.sc_gt1) begin
          cmd_o.wr_op  = ddlm_pkg::WR_REPL;
          cmd_o.status = ddlm_pkg::ST_COMPACTED;
        end else begin
          cmd_o.status = ddlm_pkg::ST_NOT_COMPACTED;
        end
        state_d = S_ST_INIT;
      end
      S_RD_CAP: begin
        cmd_o.cap_entry = 1'b1;
        state_d         = S_ST_INIT;
      end
      S_ST_INIT: begin
        cmd_o.st_init   = 1'b1;
        cmd_o.cnt_clear = 1'b1;
        state_d         = S_ST_RD;
      end
      S_ST_RD: begin
        if (sts_i.cnt_at_total) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_sel = ddlm_pkg::RD_CNT;
          state_d      = S_ST_MUL;
        end
      end
      S_ST_MUL: begin
        cmd_o.st_mul = 1'b1;
        state_d      = S_ST_ACC;
      end
      S_ST_ACC: begin
        cmd_o.st_acc  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_ST_RD;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/ddlm_dp.sv @@
// datapath for the damage list merger: bounds, entry memory, scan and statistics
// depends on ddlm_pkg; steered by ddlm_ctrl through cmd_t
module ddlm_dp #(
  parameter int MAX_OPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  ddlm_pkg::in_t   in_data_i,
  input  ddlm_pkg::cmd_t  cmd_i,
  output ddlm_pkg::sts_t  sts_o,
  output ddlm_pkg::out_t  out_data_o
);

  localparam int IW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int CW = $clog2(MAX_OPS + 1);

  ddlm_pkg::box_t   bounds_q;
  ddlm_pkg::box_t   r_q;
  logic [2:0]       mode_q;
  logic [1:0]       kind_q;
  logic [15:0]      dist_q;
  logic [7:0]       idx_q;
  logic [CW-1:0]    total_q, total_d;
  logic             fallback_q, fallback_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m1;
  logic [2:0]       status_q;
  ddlm_pkg::box_t   acc_q;
  logic [8:0]       rc_q;
  logic [8:0]       sc_q;
  logic [39:0]      pix_q;
  logic [31:0]      big_q;
  logic [31:0]      prod_q, prod_d;
  logic             is_rect_q, is_scroll_q;
  ddlm_pkg::entry_t ent_q;
  ddlm_pkg::out_t   out_q;

  ddlm_pkg::entry_t mem [MAX_OPS];
  ddlm_pkg::entry_t rd_q;
  logic             re;
  logic [IW-1:0]    raddr;
  logic             we;
  logic [IW-1:0]    waddr;
  ddlm_pkg::entry_t wdata;

  logic [2:0]       op;
  logic [2:0]       want_type;
  logic             r_ne;
  logic             aft;
  logic             same;
  logic             hit;
  logic             cont;
  logic [16:0]      dsum;
  ddlm_pkg::entry_t hit_data;
  ddlm_pkg::box_t   repl_box;
  logic [15:0]      hh;
  logic             rd_rect;
  logic             rd_scroll;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ddlm_pkg::CFG_BOUND_X: bounds_q.x <= cfg_data_i;
        ddlm_pkg::CFG_BOUND_Y: bounds_q.y <= cfg_data_i;
        ddlm_pkg::CFG_BOUND_W: bounds_q.w <= cfg_data_i;
        ddlm_pkg::CFG_BOUND_H: bounds_q.h <= cfg_data_i;
        default: bounds_q <= bounds_q;
      endcase
    end
  end

  // operation decode
  always_comb begin
    r_ne      = !ddlm_pkg::box_empty(r_q);
    want_type = (mode_q == ddlm_pkg::MODE_SCROLL) ? ddlm_pkg::T_RECT : (3'(kind_q) + 3'd1);
    op        = ddlm_pkg::OP_NONE;
    case (mode_q)
      ddlm_pkg::MODE_RECT: begin
        if (r_ne && (kind_q inside {ddlm_pkg::KIND_NORMAL, ddlm_pkg::KIND_REPAIR,
                                    ddlm_pkg::KIND_EXPOSED})) begin
          op = ddlm_pkg::OP_RECT;
        end
      end
      ddlm_pkg::MODE_SCROLL: begin
        if (r_ne && (dist_q != 16'd0)) begin
          op = (dist_q >= r_q.h) ? ddlm_pkg::OP_RECT : ddlm_pkg::OP_SCROLL;
        end
      end
      ddlm_pkg::MODE_COMPACT: op = ddlm_pkg::OP_COMPACT;
      ddlm_pkg::MODE_CLEAR:   op = ddlm_pkg::OP_CLEAR;
      ddlm_pkg::MODE_READ:    op = ddlm_pkg::OP_READ;
      default:                op = ddlm_pkg::OP_NONE;
    endcase
  end

  // merge test on the entry just read
  always_comb begin
    aft  = rd_q.etype inside {ddlm_pkg::T_REPAIR, ddlm_pkg::T_EXPOSED};
    same = (rd_q.geo == r_q);
    dsum = {1'b0, rd_q.rows} + {1'b0, dist_q};
    if (op == ddlm_pkg::OP_SCROLL) begin
      hit  = (rd_q.etype == ddlm_pkg::T_SCROLL) && same;
      cont = aft || ((rd_q.etype == ddlm_pkg::T_SCROLL) && !same);
    end else begin
      hit  = (rd_q.etype == want_type) && ddlm_pkg::box_touch(rd_q.geo, r_q);
      cont = (want_type != ddlm_pkg::T_RECT) && aft;
    end
    hit_data = rd_q;
    if (op == ddlm_pkg::OP_SCROLL) begin
      if (dsum >= {1'b0, r_q.h}) begin
        hit_data.etype = ddlm_pkg::T_RECT;
        hit_data.rows  = 16'd0;
      end else begin
        hit_data.rows = dsum[15:0];
      end
    end else begin
      hit_data.geo = ddlm_pkg::box_bound(rd_q.geo, r_q);
    end
    repl_box = ddlm_pkg::box_clip(bounds_q, acc_q);
  end

  // list writes and counters
  always_comb begin
    cnt_m1     = cnt_q - CW'(1);
    total_d    = total_q;
    fallback_d = fallback_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    case (cmd_i.wr_op)
      ddlm_pkg::WR_PUSH: begin
        we          = 1'b1;
        waddr       = total_q[IW-1:0];
        wdata.geo   = r_q;
        wdata.etype = (op == ddlm_pkg::OP_SCROLL) ? ddlm_pkg::T_SCROLL : want_type;
        wdata.rows  = (op == ddlm_pkg::OP_SCROLL) ? dist_q : 16'd0;
        total_d     = total_q + CW'(1);
      end
      ddlm_pkg::WR_OVF: begin
        we          = 1'b1;
        wdata.geo   = bounds_q;
        wdata.etype = ddlm_pkg::T_RECT;
        total_d     = CW'(1);
        fallback_d  = 1'b1;
      end
      ddlm_pkg::WR_HIT: begin
        we    = 1'b1;
        waddr = cnt_m1[IW-1:0];
        wdata = hit_data;
      end
      ddlm_pkg::WR_REPL: begin
        if (!ddlm_pkg::box_empty(repl_box)) begin
          we          = 1'b1;
          wdata.geo   = repl_box;
          wdata.etype = ddlm_pkg::T_RECT;
          total_d     = CW'(1);
        end else begin
          total_d = '0;
        end
      end
      ddlm_pkg::WR_CLEAR: begin
        total_d    = '0;
        fallback_d = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase

    cnt_d = cnt_q;
    if (cmd_i.cnt_total) begin
      cnt_d = total_q;
    end else if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end

    re    = 1'b1;
    raddr = cnt_q[IW-1:0];
    case (cmd_i.rd_sel)
      ddlm_pkg::RD_PREV: raddr = cnt_m1[IW-1:0];
      ddlm_pkg::RD_CNT:  raddr = cnt_q[IW-1:0];
      ddlm_pkg::RD_IDX:  raddr = idx_q[IW-1:0];
      default:           re = 1'b0;
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      fallback_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      total_q    <= total_d;
      fallback_q <= fallback_d;
      cnt_q      <= cnt_d;
    end
  end

  // per-entry area for statistics
  always_comb begin
    rd_rect   = rd_q.etype inside {ddlm_pkg::T_RECT, ddlm_pkg::T_REPAIR, ddlm_pkg::T_EXPOSED};
    rd_scroll = (rd_q.etype == ddlm_pkg::T_SCROLL);
    hh        = 16'd0;
    if (rd_rect) begin
      hh = rd_q.geo.h;
    end else if (rd_scroll && (rd_q.rows < rd_q.geo.h)) begin
      hh = rd_q.geo.h - rd_q.rows;
    end
    prod_d = {16'd0, rd_q.geo.w} * {16'd0, hh};
  end

  // operands, accumulators and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q    <= ddlm_pkg::box_clip(bounds_q, {in_data_i.size_h, in_data_i.size_w,
                                              in_data_i.pos_y, in_data_i.pos_x});
      mode_q <= in_data_i.mode;
      kind_q <= in_data_i.area_kind;
      dist_q <= in_data_i.scroll_distance;
      idx_q  <= in_data_i.entry_index;
      ent_q  <= '0;
    end
    if (cmd_i.cap_entry) begin
      ent_q <= rd_q;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.acc_init) begin
      acc_q <= '0;
      sc_q  <= '0;
    end
    if (cmd_i.cmp_acc) begin
      acc_q <= ddlm_pkg::box_bound(acc_q, rd_q.geo);
      if (rd_q.etype == ddlm_pkg::T_SCROLL) begin
        sc_q <= sc_q + 9'd1;
      end
    end
    if (cmd_i.st_init) begin
      rc_q  <= '0;
      sc_q  <= '0;
      pix_q <= '0;
      big_q <= '0;
    end
    if (cmd_i.st_mul) begin
      prod_q      <= prod_d;
      is_rect_q   <= rd_rect;
      is_scroll_q <= rd_scroll;
    end
    if (cmd_i.st_acc) begin
      pix_q <= pix_q + 40'(prod_q);
      if (is_rect_q) begin
        rc_q <= rc_q + 9'd1;
        if (prod_q > big_q) begin
          big_q <= prod_q;
        end
      end
      if (is_scroll_q) begin
        sc_q <= sc_q + 9'd1;
      end
    end
    if (cmd_i.out_load) begin
      out_q.status          <= status_q;
      out_q.damage_cnt      <= rc_q;
      out_q.scroll_cnt      <= sc_q;
      out_q.total_pixels    <= pix_q;
      out_q.largest_area    <= big_q;
      out_q.fallback_active <= fallback_q;
      out_q.entry_type      <= ent_q.etype;
      out_q.entry_x         <= ent_q.geo.x;
      out_q.entry_y         <= ent_q.geo.y;
      out_q.entry_width     <= ent_q.geo.w;
      out_q.entry_height    <= ent_q.geo.h;
      out_q.entry_distance  <= ent_q.rows;
    end
  end

  always_comb begin
    sts_o.op           = op;
    sts_o.fallback     = fallback_q;
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.cnt_at_total = (cnt_q == total_q);
    sts_o.full         = (total_q >= CW'(MAX_OPS));
    sts_o.idx_ok       = ({1'b0, idx_q} < 9'(total_q));
    sts_o.hit          = hit;
    sts_o.cont         = cont;
    sts_o.sc_gt1       = (sc_q > 9'd1);
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/core/display_damage_list_merger.sv @@
// top level of the display damage list merger
// depends on ddlm_pkg, ddlm_ctrl and ddlm_dp
//
// usage
//   - cfg channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 bound_x, 1 bound_y,
//     2 bound_width, 3 bound_height) and cfg_data_i; always ready, write only when idle
//   - input channel: one transfer per operation (append rect, append scroll,
//     compact, clear, read entry); in_ready_o is high only while the sequencer idles
//   - output channel: exactly one result transfer per input transfer, in order
// order of work from input transfer to result valid
//   - decode, then the backward scan or the compaction sweep over the entries,
//     then the statistics pass over every entry of the list
//   - a clear, a read, an ignored operation or one refused in fallback skips the scan;
//     a read in range captures its entry first
//   - the entry memory has one read port and one write port, one read per cycle
// one operation is in flight at a time; a finished result sits in the output
// register, so a new transfer is taken while the receiver stalls, and its
// result waits in the last state until the output register frees up
// reset empties the list, clears the fallback flag and zeroes the bounds;
// the entry memory itself is not cleared, the fill count masks it
module display_damage_list_merger #(
  parameter int MAX_OPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ddlm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ddlm_pkg::out_t out_data_o
);

  ddlm_pkg::cmd_t cmd;
  ddlm_pkg::sts_t sts;

  // config registers are plain flops, never busy
  assign cfg_ready_o = 1'b1;

  ddlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddlm_dp #(
    .MAX_OPS (MAX_OPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/ddlm_checker.sv @@
// checker for the display damage list merger: tracks bounds and the entry list,
// predicts one result per input transfer and compares it with the output channel
// depends on ddlm_pkg
module ddlm_checker
  import ddlm_pkg::*;
#(
  parameter int MAX_OPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int unsigned x, y, w, h;
  } rect_t;

  int unsigned bnd_x, bnd_y, bnd_w, bnd_h;
  rect_t       lst_geo [MAX_OPS];
  logic [2:0]  lst_type [MAX_OPS];
  int unsigned lst_dist [MAX_OPS];
  int unsigned lst_n;
  bit          fb;
  out_t        expected_results [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  function automatic bit r_empty(rect_t b);
    return b.w == 0 || b.h == 0;
  endfunction

  function automatic rect_t r_clip(rect_t a, rect_t b);
    rect_t       r;
    int unsigned l, t, rr, bo;
    r  = '{0, 0, 0, 0};
    l  = a.x > b.x ? a.x : b.x;
    t  = a.y > b.y ? a.y : b.y;
    rr = (a.x + a.w) < (b.x + b.w) ? a.x + a.w : b.x + b.w;
    bo = (a.y + a.h) < (b.y + b.h) ? a.y + a.h : b.y + b.h;
    if (rr > l && bo > t) r = '{l, t, rr - l, bo - t};
    return r;
  endfunction

  function automatic rect_t r_bbox(rect_t a, rect_t b);
    rect_t       r;
    int unsigned rr, bo;
    if (r_empty(a)) return b;
    if (r_empty(b)) return a;
    r.x = a.x < b.x ? a.x : b.x;
    r.y = a.y < b.y ? a.y : b.y;
    rr  = (a.x + a.w) > (b.x + b.w) ? a.x + a.w : b.x + b.w;
    bo  = (a.y + a.h) > (b.y + b.h) ? a.y + a.h : b.y + b.h;
    r.w = rr - r.x;
    r.h = bo - r.y;
    if (r.w > 65535) r.w = 65535;
    if (r.h > 65535) r.h = 65535;
    return r;
  endfunction

  function automatic bit r_touch(rect_t a, rect_t b);
    if (!r_empty(r_clip(a, b))) return 1;
    if (a.x == b.x && a.w == b.w && (a.y + a.h == b.y || b.y + b.h == a.y)) return 1;
    if (a.y == b.y && a.h == b.h && (a.x + a.w == b.x || b.x + b.w == a.x)) return 1;
    return 0;
  endfunction

  function automatic rect_t bounds_rect();
    return '{bnd_x, bnd_y, bnd_w, bnd_h};
  endfunction

  function automatic void wipe_list();
    for (int i = 0; i < MAX_OPS; i++) begin
      lst_geo[i]  = '{0, 0, 0, 0};
      lst_type[i] = T_NONE;
      lst_dist[i] = 0;
    end
    lst_n = 0;
  endfunction

  function automatic void replace_list(rect_t r);
    wipe_list();
    r = r_clip(bounds_rect(), r);
    if (!r_empty(r)) begin
      lst_geo[0]  = r;
      lst_type[0] = T_RECT;
      lst_n       = 1;
    end
  endfunction

  function automatic logic [2:0] go_fullscreen();
    fb = 1;
    replace_list(bounds_rect());
    return ST_FALLBACK;
  endfunction

  function automatic void push_entry(logic [2:0] t, rect_t r, int unsigned d);
    lst_geo[lst_n]  = r;
    lst_type[lst_n] = t;
    lst_dist[lst_n] = d;
    lst_n++;
  endfunction

  function automatic bit aftermath(int unsigned i);
    return lst_type[i] == T_REPAIR || lst_type[i] == T_EXPOSED;
  endfunction

  function automatic logic [2:0] merge_rect(rect_t r, logic [1:0] kind);
    logic [2:0] t;
    t = 3'(kind) + 3'd1;
    if (fb) return ST_FALLBACK;
    if (kind != KIND_NORMAL) begin
      for (int c = lst_n; c > 0 && aftermath(c - 1); c--) begin
        if (lst_type[c-1] == t && r_touch(lst_geo[c-1], r)) begin
          lst_geo[c-1] = r_bbox(lst_geo[c-1], r);
          return ST_MERGED;
        end
      end
    end
    if (lst_n > 0 && lst_type[lst_n-1] == t && r_touch(lst_geo[lst_n-1], r)) begin
      lst_geo[lst_n-1] = r_bbox(lst_geo[lst_n-1], r);
      return ST_MERGED;
    end
    if (lst_n >= MAX_OPS) return go_fullscreen();
    push_entry(t, r, 0);
    return ST_QUEUED;
  endfunction

  function automatic logic [2:0] merge_scroll(rect_t r, int unsigned d);
    rect_t e;
    if (r_empty(r) || d == 0) return ST_IGNORED;
    if (d >= r.h) return merge_rect(r, KIND_NORMAL);
    if (fb) return ST_FALLBACK;
    for (int c = lst_n; c > 0; c--) begin
      if (aftermath(c - 1)) continue;
      if (lst_type[c-1] != T_SCROLL) break;
      e = lst_geo[c-1];
      if (e.x != r.x || e.y != r.y || e.w != r.w || e.h != r.h) continue;
      if (lst_dist[c-1] + d >= r.h) begin
        lst_type[c-1] = T_RECT;
        lst_dist[c-1] = 0;
      end else begin
        lst_dist[c-1] += d;
      end
      return ST_MERGED;
    end
    if (lst_n >= MAX_OPS) return go_fullscreen();
    push_entry(T_SCROLL, r, d);
    return ST_QUEUED;
  endfunction

  function automatic logic [2:0] compact_list();
    rect_t acc;
    int    ns;
    acc = '{0, 0, 0, 0};
    ns  = 0;
    for (int i = 0; i < lst_n; i++) if (lst_type[i] == T_SCROLL) ns++;
    if (ns <= 1 || fb) return ST_NOT_COMPACTED;
    for (int i = 0; i < lst_n; i++) acc = r_bbox(acc, lst_geo[i]);
    if (r_empty(acc)) return ST_NOT_COMPACTED;
    replace_list(acc);
    return ST_COMPACTED;
  endfunction

  function automatic out_t predict_result(in_t d);
    out_t        o;
    rect_t       r;
    longint unsigned tot, big, a;
    int unsigned ix;
    o   = '0;
    tot = 0;
    big = 0;
    r   = r_clip(bounds_rect(), '{d.pos_x, d.pos_y, d.size_w, d.size_h});
    case (d.mode)
      MODE_RECT: begin
        if (d.area_kind <= KIND_EXPOSED && !r_empty(r)) o.status = merge_rect(r, d.area_kind);
      end
      MODE_SCROLL:  o.status = merge_scroll(r, d.scroll_distance);
      MODE_COMPACT: o.status = compact_list();
      MODE_CLEAR: begin
        wipe_list();
        fb       = 0;
        o.status = ST_DONE;
      end
      MODE_READ: begin
        o.status = ST_DONE;
        ix = d.entry_index;
        if (ix < lst_n) begin
          o.entry_type     = lst_type[ix];
          o.entry_x        = 16'(lst_geo[ix].x);
          o.entry_y        = 16'(lst_geo[ix].y);
          o.entry_width    = 16'(lst_geo[ix].w);
          o.entry_height   = 16'(lst_geo[ix].h);
          o.entry_distance = 16'(lst_dist[ix]);
        end
      end
      default: o.status = ST_IGNORED;
    endcase
    for (int i = 0; i < lst_n; i++) begin
      if (lst_type[i] >= T_RECT && lst_type[i] <= T_EXPOSED) begin
        a = longint'(lst_geo[i].w) * lst_geo[i].h;
        o.damage_cnt++;
        tot += a;
        if (a > big) big = a;
      end else if (lst_type[i] == T_SCROLL) begin
        o.scroll_cnt++;
        if (lst_dist[i] < lst_geo[i].h)
          tot += longint'(lst_geo[i].w) * (lst_geo[i].h - lst_dist[i]);
      end
    end
    o.total_pixels    = 40'(tot);
    o.largest_area    = 32'(big);
    o.fallback_active = fb;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic compare_result(out_t g, out_t e);
    if (g.status != e.status) report_mismatch("status", g.status, e.status);
    if (g.damage_cnt != e.damage_cnt) report_mismatch("damage_cnt", g.damage_cnt, e.damage_cnt);
    if (g.scroll_cnt != e.scroll_cnt)
      report_mismatch("scroll_cnt", g.scroll_cnt, e.scroll_cnt);
    if (g.total_pixels != e.total_pixels)
      report_mismatch("total_pixels", g.total_pixels, e.total_pixels);
    if (g.largest_area != e.largest_area)
      report_mismatch("largest_area", g.largest_area, e.largest_area);
    if (g.fallback_active != e.fallback_active)
      report_mismatch("fallback_active", g.fallback_active, e.fallback_active);
    if (g.entry_type != e.entry_type) report_mismatch("entry_type", g.entry_type, e.entry_type);
    if (g.entry_x != e.entry_x) report_mismatch("entry_x", g.entry_x, e.entry_x);
    if (g.entry_y != e.entry_y) report_mismatch("entry_y", g.entry_y, e.entry_y);
    if (g.entry_width != e.entry_width)
      report_mismatch("entry_width", g.entry_width, e.entry_width);
    if (g.entry_height != e.entry_height)
      report_mismatch("entry_height", g.entry_height, e.entry_height);
    if (g.entry_distance != e.entry_distance)
      report_mismatch("entry_distance", g.entry_distance, e.entry_distance);
  endtask

  initial begin
    fails = 0;
    bnd_x = 0; bnd_y = 0; bnd_w = 0; bnd_h = 0;
    fb    = 0;
    wipe_list();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BOUND_X: bnd_x = cfg_data_i;
          CFG_BOUND_Y: bnd_y = cfg_data_i;
          CFG_BOUND_W: bnd_w = cfg_data_i;
          default:     bnd_h = cfg_data_i;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("result transfer with nothing expected at %0t", $realtime);
          fails++;
        end else begin
          compare_result(out_data_i, expected_results.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_result(in_data_i));
    end
  end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the display damage list merger: clock, reset, bounds
// writes and operation stimulus; depends on ddlm_pkg, ddlm_checker and the rtl
module tb_top;
  import ddlm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int          fail_count;
  int          pending;
  bit          calm;      // no idling on either side while set

  display_damage_list_merger u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ddlm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // receiver stalls about a quarter of the time unless calm
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  // one bounds register write, transfer on the cfg channel
  task automatic write_bound(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop valid, drain all results, then give the block its worst-case latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_bounds(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    wait_idle();
    write_bound(CFG_BOUND_X, 16'(x));
    write_bound(CFG_BOUND_Y, 16'(y));
    write_bound(CFG_BOUND_W, 16'(w));
    write_bound(CFG_BOUND_H, 16'(h));
    cfg_valid <= 1'b0;
  endtask

  // one operation transfer, with a random gap in front of it unless calm
  task automatic send_op(in_t d);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 24) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic op(logic [2:0] m, logic [1:0] k, int unsigned x, int unsigned y,
                    int unsigned w, int unsigned h, int unsigned rows, int unsigned idx);
    in_t d;
    d.mode            = m;
    d.area_kind       = k;
    d.pos_x           = 16'(x);
    d.pos_y           = 16'(y);
    d.size_w          = 16'(w);
    d.size_h          = 16'(h);
    d.scroll_distance = 16'(rows);
    d.entry_index     = 8'(idx);
    send_op(d);
  endtask

  // random operation, mostly small rectangles in a 256 x 256 window so merges
  // and identical scrolls happen; some fully random noise
  task automatic random_op();
    in_t         d;
    int unsigned p;
    d = in_t'(93'({$urandom, $urandom, $urandom, $urandom}));
    p = $urandom_range(99);
    if (p < 85) begin
      d.pos_x  = 16'($urandom_range(255));
      d.pos_y  = 16'($urandom_range(255));
      d.size_w = 16'($urandom_range(64));
      d.size_h = 16'($urandom_range(64));
      if ($urandom_range(3) == 0) begin
        d.pos_x = 16'(8 * $urandom_range(3));
        d.pos_y = 16'(8 * $urandom_range(3));
        d.size_w = 16'd16;
        d.size_h = 16'd16;
      end
      d.scroll_distance = 16'($urandom_range(20));
      d.entry_index     = 8'($urandom_range(17));
      d.area_kind       = 2'($urandom_range(2));
      p = $urandom_range(99);
      if (p < 45)      d.mode = MODE_RECT;
      else if (p < 80) d.mode = MODE_SCROLL;
      else if (p < 87) d.mode = MODE_COMPACT;
      else if (p < 91) d.mode = MODE_CLEAR;
      else             d.mode = MODE_READ;
    end
    send_op(d);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero bounds: every append ignored
    op(MODE_RECT, KIND_NORMAL, 0, 0, 10, 10, 0, 0);
    op(MODE_SCROLL, KIND_NORMAL, 0, 0, 10, 10, 1, 0);

    set_bounds(0, 0, 256, 256);
    // directed: merges, aftermath, scrolls, reads, unused codes
    op(MODE_RECT, KIND_NORMAL, 0, 0, 16, 16, 0, 0);
    op(MODE_RECT, KIND_NORMAL, 16, 0, 16, 16, 0, 0);     // edge adjacent merge
    op(MODE_RECT, KIND_REPAIR, 40, 40, 8, 8, 0, 0);
    op(MODE_RECT, KIND_EXPOSED, 100, 100, 8, 8, 0, 0);
    op(MODE_RECT, KIND_REPAIR, 44, 44, 8, 8, 0, 0);      // search back through aftermath
    op(MODE_RECT, 2'd3, 0, 0, 16, 16, 0, 0);             // unused kind
    op(MODE_SCROLL, KIND_NORMAL, 8, 8, 32, 32, 0, 0);    // zero distance
    op(MODE_SCROLL, KIND_NORMAL, 8, 8, 32, 32, 40, 0);   // long scroll
    op(MODE_SCROLL, KIND_NORMAL, 64, 64, 32, 32, 5, 0);
    op(MODE_SCROLL, KIND_NORMAL, 64, 64, 32, 32, 30, 0); // sum reaches height
    op(MODE_SCROLL, KIND_NORMAL, 64, 64, 32, 32, 3, 0);
    op(MODE_SCROLL, KIND_NORMAL, 65535, 65535, 65535, 65535, 65535, 0);
    op(MODE_READ, KIND_NORMAL, 0, 0, 0, 0, 0, 0);
    op(MODE_READ, KIND_NORMAL, 0, 0, 0, 0, 0, 255);      // out of range
    op(MODE_COMPACT, KIND_NORMAL, 0, 0, 0, 0, 0, 0);     // one scroll: refused
    op(MODE_SCROLL, KIND_NORMAL, 128, 0, 32, 32, 2, 0);
    op(MODE_COMPACT, KIND_NORMAL, 0, 0, 0, 0, 0, 0);
    op(3'd7, KIND_NORMAL, 0, 0, 0, 0, 0, 0);             // unused mode
    for (int i = 0; i < 18; i++) op(MODE_RECT, KIND_NORMAL, 14 * i, 0, 4, 4, 0, 0);
    op(MODE_RECT, KIND_NORMAL, 0, 0, 1, 1, 0, 0);        // while in fallback
    op(MODE_COMPACT, KIND_NORMAL, 0, 0, 0, 0, 0, 0);
    op(MODE_CLEAR, KIND_NORMAL, 0, 0, 0, 0, 0, 0);

    // wide bounding box: entries at the far edges, then move the bounds
    set_bounds(0, 0, 65535, 65535);
    op(MODE_RECT, KIND_NORMAL, 0, 0, 65535, 65535, 0, 0);
    op(MODE_READ, KIND_NORMAL, 0, 0, 0, 0, 0, 0);
    set_bounds(65535, 65535, 65535, 65535);
    op(MODE_RECT, KIND_NORMAL, 65535, 65535, 1, 1, 0, 0);
    op(MODE_SCROLL, KIND_NORMAL, 0, 0, 65535, 65535, 1, 0);
    op(MODE_READ, KIND_NORMAL, 0, 0, 0, 0, 0, 0);
    op(MODE_CLEAR, KIND_NORMAL, 0, 0, 0, 0, 0, 0);

    // random phases across several bounds settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_bounds(0, 0, 256, 256);
        1: set_bounds(32, 16, 160, 200);
        2: set_bounds($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(65535));
        3: set_bounds(0, 0, 65535, 65535);
        4: set_bounds(0, 0, 0, 100);
        default: set_bounds(8, 8, 120, 120);
      endcase
      calm = (ph == 3);
      for (int n = 0; n < 180; n++) begin
        random_op();
        if (ph == 1 && n == 90) begin
          // sender holds off until the block has caught up
          wait_idle();
        end
      end
      calm = 1'b0;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
